[hw/rtl/ascii_frame_checksum_deframer_core_assert.svh]
// Assertion macros shared by the deframer RTL.
`ifndef ASCII_FRAME_CHECKSUM_DEFRAMER_CORE_ASSERT_SVH
`define ASCII_FRAME_CHECKSUM_DEFRAMER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AFCD_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
`define AFCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define AFCD_ASSERT_IMPLIES(label, ante, cons)
`define AFCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/afcd_pkg.sv]
// Package: constants, types and the body byte update of the deframer.
`timescale 1ns / 1ps
`default_nettype none
package afcd_pkg;

   localparam int unsigned LEN_BITS_DEFAULT = 16;
   localparam int unsigned LEN_OUT_W        = 16;

   localparam logic [7:0] CH_OPEN  = 8'h3E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_CHECKSUM = 2'd1,
      STATUS_MISMATCH    = 2'd2,
      STATUS_NO_SLASH    = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      status_type          status;
      logic [6:0]          calc_checksum;
      logic [7:0]          received_checksum;
      logic [LEN_OUT_W-1:0] body_length;
      logic [LEN_OUT_W-1:0] address_length;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } byte_stage_type;

   typedef struct packed {
      logic [7:0] running_sum;
      logic [7:0] sum_at_star;
      logic       star_seen;
      logic       after_star_valid;
      logic [7:0] after_star_byte;
      logic       slash_seen;
      logic       slash_before_star;
   } flags_type;

   typedef struct packed {
      logic [7:0]           sum_at_star;
      logic                 star_seen;
      logic                 after_star_valid;
      logic [7:0]           after_star_byte;
      logic                 slash_before_star;
      logic [LEN_OUT_W-1:0] body_length;
      logic [LEN_OUT_W-1:0] address_length;
   } frame_summary_type;

   function automatic flags_type body_flags(flags_type f, logic [7:0] b);
      flags_type r;
      r = f;
      r.running_sum = f.running_sum + b;
      if (b == CH_STAR) begin
         r.star_seen         = 1'b1;
         r.sum_at_star       = r.running_sum;
         r.after_star_valid  = 1'b0;
         r.after_star_byte   = '0;
         r.slash_before_star = f.slash_seen;
      end else if (f.star_seen && !f.after_star_valid) begin
         r.after_star_valid = 1'b1;
         r.after_star_byte  = b;
      end
      if (!f.slash_seen && b == CH_SLASH) begin
         r.slash_seen = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/afcd_stream_if.sv]
// Valid/ready stream interface used for the byte and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface afcd_stream_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/afcd_input_stage.sv]
// Input register: holds one received byte until the frame tracker takes it.
`timescale 1ns / 1ps
`default_nettype none
module afcd_input_stage
   import afcd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   afcd_stream_if.sink   req,
   input  wire logic     advance,
   output byte_stage_type stage
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req.data.rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule
`default_nettype wire

[hw/rtl/afcd_frame_state.sv]
// Frame tracker: framing state, running sums and saturating length counters.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_frame_checksum_deframer_core_assert.svh"
module afcd_frame_state
   import afcd_pkg::*;
#(
   parameter int unsigned LEN_BITS = LEN_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire byte_stage_type   stage,
   input  wire logic             advance,
   output logic                  close_req,
   output frame_summary_type     summary
);

   logic                in_frame_ff;
   logic                in_frame_in;
   logic                cr_pending_ff;
   logic                cr_pending_in;
   flags_type           flags_ff;
   flags_type           flags_in;
   flags_type           flags_mid;
   flags_type           flags_end;
   logic [LEN_BITS-1:0] length_ff;
   logic [LEN_BITS-1:0] length_in;
   logic [LEN_BITS-1:0] length_mid;
   logic [LEN_BITS-1:0] length_end;
   logic [LEN_BITS-1:0] addr_ff;
   logic [LEN_BITS-1:0] addr_in;
   logic [LEN_BITS-1:0] addr_mid;
   logic [LEN_BITS-1:0] addr_end;
   logic [LEN_OUT_W-1:0] body_len_out;
   logic [LEN_OUT_W-1:0] addr_len_out;
   logic [7:0]          b;

   function automatic logic [LEN_BITS-1:0] sat_inc(logic [LEN_BITS-1:0] v);
      return (v == '1) ? v : v + LEN_BITS'(1);
   endfunction

   assign b         = stage.rx_byte;
   assign close_req = stage.valid && in_frame_ff && cr_pending_ff && (b == CH_LF);

   // fold a pending CR in as a body byte, then the new byte unless it is a CR
   always_comb begin
      flags_mid  = flags_ff;
      length_mid = length_ff;
      addr_mid   = addr_ff;
      if (cr_pending_ff) begin
         flags_mid  = body_flags(flags_ff, CH_CR);
         length_mid = sat_inc(length_ff);
         if (!flags_ff.slash_seen) begin
            addr_mid = sat_inc(addr_ff);
         end
      end
      flags_end  = flags_mid;
      length_end = length_mid;
      addr_end   = addr_mid;
      if (b != CH_CR) begin
         flags_end  = body_flags(flags_mid, b);
         length_end = sat_inc(length_mid);
         if (!flags_mid.slash_seen && b != CH_SLASH) begin
            addr_end = sat_inc(addr_mid);
         end
      end
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      cr_pending_in = cr_pending_ff;
      flags_in      = flags_ff;
      length_in     = length_ff;
      addr_in       = addr_ff;
      if (advance) begin
         if (!in_frame_ff) begin
            if (b == CH_OPEN) begin
               in_frame_in          = 1'b1;
               cr_pending_in        = 1'b0;
               flags_in             = '0;
               flags_in.running_sum = CH_OPEN;
               length_in            = LEN_BITS'(1);
               addr_in              = '0;
            end
         end else if (close_req) begin
            in_frame_in   = 1'b0;
            cr_pending_in = 1'b0;
            flags_in      = '0;
            length_in     = '0;
            addr_in       = '0;
         end else begin
            cr_pending_in = (b == CH_CR);
            flags_in      = flags_end;
            length_in     = length_end;
            addr_in       = addr_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         cr_pending_ff <= 1'b0;
         flags_ff      <= '0;
         length_ff     <= '0;
         addr_ff       <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         cr_pending_ff <= cr_pending_in;
         flags_ff      <= flags_in;
         length_ff     <= length_in;
         addr_ff       <= addr_in;
      end
   end

   if (LEN_BITS > LEN_OUT_W) begin : g_clamp
      assign body_len_out = (|length_ff[LEN_BITS-1:LEN_OUT_W]) ? '1
                                                               : length_ff[LEN_OUT_W-1:0];
      assign addr_len_out = (|addr_ff[LEN_BITS-1:LEN_OUT_W]) ? '1
                                                             : addr_ff[LEN_OUT_W-1:0];
   end else begin : g_extend
      assign body_len_out = LEN_OUT_W'(length_ff);
      assign addr_len_out = LEN_OUT_W'(addr_ff);
   end

   assign summary.sum_at_star       = flags_ff.sum_at_star;
   assign summary.star_seen         = flags_ff.star_seen;
   assign summary.after_star_valid  = flags_ff.after_star_valid;
   assign summary.after_star_byte   = flags_ff.after_star_byte;
   assign summary.slash_before_star = flags_ff.slash_before_star;
   assign summary.body_length       = body_len_out;
   assign summary.address_length    = addr_len_out;

   `AFCD_ASSERT_NEXT(a_close_ends_frame, advance && close_req, !in_frame_ff && !cr_pending_ff)
   `AFCD_ASSERT_IMPLIES(a_cr_only_in_frame, cr_pending_ff, in_frame_ff)
   `AFCD_ASSERT_NEXT(a_open_sets_length, advance && !in_frame_ff && b == CH_OPEN,
                     in_frame_ff && length_ff == LEN_BITS'(1))

endmodule
`default_nettype wire

[hw/rtl/afcd_result_stage.sv]
// Result register: forms the frame verdict and holds it until transfer.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_frame_checksum_deframer_core_assert.svh"
module afcd_result_stage
   import afcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire frame_summary_type summary,
   afcd_stream_if.source          rsp,
   output logic                   rsp_free
);

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   rsp_payload_type verdict;
   logic [6:0]      calc;
   logic [7:0]      rcv;

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      calc = summary.star_seen ? summary.sum_at_star[6:0] : 7'd0;
      rcv  = summary.after_star_valid ? summary.after_star_byte : 8'd0;
      verdict.calc_checksum     = calc;
      verdict.received_checksum = rcv;
      verdict.body_length       = summary.body_length;
      verdict.address_length    = summary.slash_before_star ? summary.address_length : '0;
      if (!summary.star_seen || !summary.after_star_valid) begin
         verdict.status = STATUS_NO_CHECKSUM;
      end else if (rcv != {1'b0, calc}) begin
         verdict.status = STATUS_MISMATCH;
      end else if (!summary.slash_before_star) begin
         verdict.status = STATUS_NO_SLASH;
      end else begin
         verdict.status = STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = verdict;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   `AFCD_ASSERT_IMPLIES(a_no_overwrite, load, !rsp_valid_ff || rsp.ready)
   `AFCD_ASSERT_IMPLIES(a_ok_matches, rsp_valid_ff && rsp_data_ff.status == STATUS_OK,
                        rsp_data_ff.received_checksum == {1'b0, rsp_data_ff.calc_checksum})

endmodule
`default_nettype wire

[hw/rtl/ascii_frame_checksum_deframer_core.sv]
// Top level of the ASCII frame deframer with 7-bit additive checksum.
//
//   channel   dir   payload                                        role
//   req_ch    in    rx_byte                                        received bytes
//   rsp_ch    out   status, calc_checksum, received_checksum,      one verdict
//                   body_length, address_length                    per frame
//
// One byte is taken per cycle while the input is not stalled; a byte is held in the
// input register, then updates the frame state as it advances.
// rsp_ch.valid rises once the closing LF has advanced out of the input register
// and its verdict has been registered in the result stage.
// A held verdict stalls the next closing LF in the input register and the input
// behind it; bytes ahead of that LF keep flowing.
// Synchronous active-high reset clears framing state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none
module ascii_frame_checksum_deframer_core
   import afcd_pkg::*;
#(
   parameter int unsigned LEN_BITS = LEN_BITS_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   afcd_stream_if.sink   req_ch,
   afcd_stream_if.source rsp_ch
);

   byte_stage_type    stage;
   frame_summary_type summary;
   logic              close_req;
   logic              rsp_free;
   logic              advance;

   assign advance = stage.valid && (!close_req || rsp_free);

   afcd_input_stage u_input (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   afcd_frame_state #(
      .LEN_BITS (LEN_BITS)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .close_req (close_req),
      .summary   (summary)
   );

   afcd_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && close_req),
      .summary  (summary),
      .rsp      (rsp_ch),
      .rsp_free (rsp_free)
   );

endmodule
`default_nettype wire

[sim/ascii_frame_checksum_deframer_core_test.sv]
// Self-checking testbench for the ASCII frame checksum deframer core.
`timescale 1ns / 1ps
module ascii_frame_checksum_deframer_core_test;
   import afcd_pkg::*;

   class frame_verdict_board;
      bit                 in_frame;
      bit                 cr_pending;
      bit [7:0]           running_sum;
      bit [7:0]           star_sum;
      bit                 star_seen;
      bit                 tail_valid;
      bit [7:0]           tail_byte;
      bit                 slash_seen;
      bit                 slash_before_star;
      bit [LEN_OUT_W-1:0] body_count;
      bit [LEN_OUT_W-1:0] addr_count;
      rsp_payload_type    verdicts[$];
      int                 errors;

      function void clear();
         in_frame          = 1'b0;
         cr_pending        = 1'b0;
         running_sum       = '0;
         star_sum          = '0;
         star_seen         = 1'b0;
         tail_valid        = 1'b0;
         tail_byte         = '0;
         slash_seen        = 1'b0;
         slash_before_star = 1'b0;
         body_count        = '0;
         addr_count        = '0;
      endfunction

      function void take_body(bit [7:0] b);
         running_sum += b;
         if (body_count != '1) body_count++;
         if (b == CH_STAR) begin
            star_seen         = 1'b1;
            star_sum          = running_sum;
            tail_valid        = 1'b0;
            tail_byte         = '0;
            slash_before_star = slash_seen;
         end else if (star_seen && !tail_valid) begin
            tail_valid = 1'b1;
            tail_byte  = b;
         end
         if (!slash_seen) begin
            if (b == CH_SLASH) slash_seen = 1'b1;
            else if (addr_count != '1) addr_count++;
         end
      endfunction

      function void note_byte(bit [7:0] b);
         rsp_payload_type v;
         if (!in_frame) begin
            if (b == CH_OPEN) begin
               clear();
               in_frame    = 1'b1;
               running_sum = CH_OPEN;
               body_count  = LEN_OUT_W'(1);
            end
            return;
         end
         if (cr_pending) begin
            if (b == CH_LF) begin
               v.calc_checksum     = star_seen ? star_sum[6:0] : '0;
               v.received_checksum = tail_valid ? tail_byte : '0;
               if (!star_seen || !tail_valid) v.status = STATUS_NO_CHECKSUM;
               else if (v.received_checksum != {1'b0, v.calc_checksum}) v.status = STATUS_MISMATCH;
               else if (!slash_before_star) v.status = STATUS_NO_SLASH;
               else v.status = STATUS_OK;
               v.body_length    = body_count;
               v.address_length = slash_before_star ? addr_count : '0;
               verdicts.push_back(v);
               clear();
               return;
            end
            cr_pending = 1'b0;
            take_body(CH_CR);
         end
         if (b == CH_CR) cr_pending = 1'b1;
         else take_body(b);
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_verdict(rsp_payload_type got);
         rsp_payload_type want;
         if (verdicts.size() == 0) begin
            report($sformatf("verdict with no frame closed, status %0d", got.status));
            return;
         end
         want = verdicts.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.calc_checksum !== want.calc_checksum)
            report($sformatf("calc_checksum got %0h want %0h",
                             got.calc_checksum, want.calc_checksum));
         if (got.received_checksum !== want.received_checksum)
            report($sformatf("received_checksum got %0h want %0h",
                             got.received_checksum, want.received_checksum));
         if (got.body_length !== want.body_length)
            report($sformatf("body_length got %0d want %0d",
                             got.body_length, want.body_length));
         if (got.address_length !== want.address_length)
            report($sformatf("address_length got %0d want %0d",
                             got.address_length, want.address_length));
      endtask

      function int waiting();
         return verdicts.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   int unsigned calm;
   int unsigned frame_bytes;

   frame_verdict_board sb = new;

   afcd_stream_if #(.payload_type(req_payload_type)) req_ch ();
   afcd_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   ascii_frame_checksum_deframer_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned pick_gap(bit quick);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92 || quick) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] filler();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_STAR || b == CH_SLASH);
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int unsigned n;
      if (calm != 0) begin
         calm--;
         n = 0;
      end else begin
         n = pick_gap(1'b0);
         if ($urandom_range(0, 63) == 0) calm = $urandom_range(16, 96);
      end
      if (n != 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= '{rx_byte: b};
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_crlf();
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // send head (ending in a star), its checksum xor flip, then tail and CR LF
   task automatic send_checked(input string head, input logic [7:0] flip, input string tail);
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < head.len(); i++) sum += head[i];
      send_text(head);
      send_byte({1'b0, sum[6:0]} ^ flip);
      send_text(tail);
      send_crlf();
   endtask

   task automatic send_random_frame();
      logic [7:0]  q[$];
      logic [7:0]  sum;
      logic [7:0]  cs;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      q.push_back(CH_OPEN);
      repeat ($urandom_range(0, 6)) q.push_back(filler());
      if (kind >= 8) q.push_back(CH_SLASH);
      repeat ($urandom_range(0, 12)) begin
         case ($urandom_range(0, 15))
            0: q.push_back(CH_STAR);
            1: q.push_back(CH_SLASH);
            2: q.push_back(CH_OPEN);
            3: q.push_back(CH_CR);
            default: q.push_back(filler());
         endcase
      end
      if (kind >= 16) begin
         q.push_back(CH_STAR);
         if (kind >= 22) begin
            sum = '0;
            foreach (q[i]) sum += q[i];
            cs = {1'b0, sum[6:0]};
            if (kind < 32) cs ^= 8'h01 << $urandom_range(0, 7);
            q.push_back(cs);
            repeat ($urandom_range(0, 2)) q.push_back(filler());
         end
      end
      if ($urandom_range(0, 9) == 0) q.push_back(CH_CR);
      q.push_back(CH_CR);
      q.push_back(CH_LF);
      frame_bytes += q.size();
      foreach (q[i]) send_byte(q[i]);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_verdict(rsp_ch.data);
         if (req_ch.valid && req_ch.ready) sb.note_byte(req_ch.data.rx_byte);
      end
   end

   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 8)) @(negedge clock);
         stall = pick_gap(1'b0);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [7:0]  b;
      int unsigned r;
      sb.clear();
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle bytes, dropped
      send_byte(8'h00);
      send_byte(8'hFF);
      send_crlf();
      send_byte(CH_STAR);

      send_checked(">ab/cd*", 8'h00, "");
      send_checked(">/*", 8'h80, "");
      send_checked(">x/y*", 8'h01, "");
      send_checked(">nosl*", 8'h00, "/z");
      send_checked(">>a/>*", 8'h00, "");
      send_checked(">a/*b*", 8'h00, "");
      send_checked(">q/r\015s*", 8'h00, "");
      send_checked(">k/m*", 8'h00, "\015");
      send_text(">/ab*");
      send_crlf();
      send_text(">");
      send_crlf();
      send_text(">no star");
      send_crlf();

      frame_bytes = 0;
      while (frame_bytes < 1450) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            repeat ($urandom_range(1, 4)) begin
               do b = 8'($urandom_range(0, 255)); while (b == CH_OPEN);
               send_byte(b);
            end
         end else if (r < 30) begin
            repeat ($urandom_range(3, 15)) send_byte(8'($urandom_range(0, 255)));
            send_crlf();
         end
         send_random_frame();
      end
      req_ch.valid <= 1'b0;

      while (sb.waiting() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
